FILE: rtl/ctrgb_pkg.sv
// Shared types, constants and tables for the colour temperature to RGB unit.
// Used by every cell module and by the top level; depends on nothing.
`default_nettype none
package ctrgb_pkg;

  localparam int unsigned CHANNEL_BITS = 8;
  localparam logic [CHANNEL_BITS-1:0] FULL_SCALE = {CHANNEL_BITS{1'b1}};

  localparam int unsigned LOG_STEPS  = 30;
  localparam int unsigned EXP_TERMS  = 16;
  localparam int unsigned DIV_STEPS  = 25;
  localparam int unsigned FLG_DEPTH  = LOG_STEPS + 5;
  localparam int unsigned CTX_DEPTH  = 3 * EXP_TERMS + DIV_STEPS + 1;
  localparam int unsigned NSTAGE     = 1 + LOG_STEPS + 6 + 3 * EXP_TERMS + DIV_STEPS + 3;

  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [27:0] LN2_Q28     = 28'd186065279;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [23:0] GREEN_LOG_A = 24'd6518919;
  localparam logic [27:0] GREEN_LOG_B = 28'd10559132;
  localparam logic [23:0] BLUE_LOG_A  = 24'd9077898;
  localparam logic [27:0] BLUE_LOG_B  = 28'd19991416;
  localparam logic [24:0] RED_POW_C   = 25'd21607136;
  localparam logic [27:0] RED_POW_P   = 28'd143027521;
  localparam logic [24:0] GREEN_POW_C = 25'd18882375;
  localparam logic [27:0] GREEN_POW_P = 28'd81083452;
  localparam logic [24:0] RECIP_255   = 25'd16843009;

  typedef struct packed {
    logic [30:0] m;
    logic [3:0]  e;
    logic [29:0] frac;
  } log_t;

  typedef struct packed {
    logic [30:0] term;
    logic [30:0] sum;
    logic [29:0] y;
    logic [4:0]  k;
  } exp_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [30:0] dvs;
    logic [24:0] quo;
  } div_t;

  typedef struct packed {
    logic lo;
    logic bfull;
    logic bzero;
    logic smalla;
    logic smallb;
  } flags_t;

  typedef struct packed {
    logic        lo;
    logic        bfull;
    logic        bzero;
    logic [27:0] ga;
    logic [27:0] bb;
    logic [1:0]  ipr;
    logic [1:0]  ipg;
  } ctx_t;

  // Evaluated at elaboration only, mirroring the squaring log.
  function automatic logic [33:0] log2_q30_const(input logic [15:0] n);
    logic [63:0] m;
    logic [33:0] res;
    int          e;
    e = 0;
    for (int j = 0; j < 15; j++) begin
      if ((n >> (j + 1)) != 16'd0) e = j + 1;
    end
    m   = 64'(n) << (30 - e);
    res = 34'(e) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  localparam logic [33:0] LOG2_100 = log2_q30_const(16'd100);

  // floor(2^32 / k); for k of one the all-ones word, fixed by the correction step.
  function automatic logic [31:0] recip_k(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd1:    r = 32'hFFFFFFFF;
      5'd2:    r = 32'd2147483648;
      5'd3:    r = 32'd1431655765;
      5'd4:    r = 32'd1073741824;
      5'd5:    r = 32'd858993459;
      5'd6:    r = 32'd715827882;
      5'd7:    r = 32'd613566756;
      5'd8:    r = 32'd536870912;
      5'd9:    r = 32'd477218588;
      5'd10:   r = 32'd429496729;
      5'd11:   r = 32'd390451572;
      5'd12:   r = 32'd357913941;
      5'd13:   r = 32'd330382099;
      5'd14:   r = 32'd306783378;
      5'd15:   r = 32'd286331153;
      5'd16:   r = 32'd268435456;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ctrgb_log_cell.sv
// One squaring step of the base-2 logarithm: yields one fraction bit.
// Depends on ctrgb_pkg.
`default_nettype none
module ctrgb_log_cell (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire ctrgb_pkg::log_t d_i,
  output ctrgb_pkg::log_t      d_o
);
  import ctrgb_pkg::*;

  logic [61:0] sq;
  logic [31:0] t;
  log_t        d_nxt;
  log_t        d_r;

  always_comb begin
    sq = 62'(d_i.m) * 62'(d_i.m);
    t  = sq[61:30];
    d_nxt.e = d_i.e;
    if (t[31]) begin
      d_nxt.m    = t[31:1];
      d_nxt.frac = {d_i.frac[28:0], 1'b1};
    end else begin
      d_nxt.m    = t[30:0];
      d_nxt.frac = {d_i.frac[28:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

FILE: rtl/ctrgb_exp_cell.sv
// One Taylor term of exp(y) over three stages: multiply, reciprocal, correction.
// Depends on ctrgb_pkg.
`default_nettype none
module ctrgb_exp_cell (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire ctrgb_pkg::exp_t d_i,
  output ctrgb_pkg::exp_t      d_o
);
  import ctrgb_pkg::*;

  logic [60:0] prod_r;
  exp_t        a_r;
  logic [30:0] x_r;
  logic [30:0] q0_r;
  exp_t        b_r;
  exp_t        c_r;

  logic [30:0] x;
  logic [62:0] pm;
  logic [30:0] rem;
  logic [30:0] q;
  exp_t        c_nxt;

  always_comb begin
    x  = prod_r[60:30];
    pm = 63'(x) * 63'(recip_k(a_r.k));
  end

  // The reciprocal quotient is at most one short of the true one.
  always_comb begin
    rem = x_r - 31'(q0_r * 31'(b_r.k));
    q   = (rem >= 31'(b_r.k)) ? q0_r + 31'd1 : q0_r;
    c_nxt.term = q;
    c_nxt.sum  = b_r.sum + q;
    c_nxt.y    = b_r.y;
    c_nxt.k    = b_r.k + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 61'(d_i.term) * 61'(d_i.y);
      a_r    <= d_i;
      x_r    <= x;
      q0_r   <= pm[62:32];
      b_r    <= a_r;
      c_r    <= c_nxt;
    end
  end

  assign d_o = c_r;

endmodule
`default_nettype wire

FILE: rtl/ctrgb_div_cell.sv
// One restoring division step: yields one quotient bit.
// Depends on ctrgb_pkg.
`default_nettype none
module ctrgb_div_cell (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire ctrgb_pkg::div_t d_i,
  output ctrgb_pkg::div_t      d_o
);
  import ctrgb_pkg::*;

  logic [31:0] t;
  logic        ge;
  div_t        d_nxt;
  div_t        d_r;

  always_comb begin
    t  = {d_i.rem, 1'b0};
    ge = (t >= {1'b0, d_i.dvs});
    d_nxt.dvs = d_i.dvs;
    d_nxt.rem = ge ? 31'(t - {1'b0, d_i.dvs}) : t[30:0];
    d_nxt.quo = {d_i.quo[23:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

FILE: rtl/color_temperature_to_rgb_unit.sv
// Colour temperature to RGB: log chain, Taylor exp chain, divider chain, scaling.
// One item per cycle sustained while results are taken.
// Throughput is set by the fully pipelined cell chains (30 log, 48 exp, 25 divide).
// The whole pipeline stalls while a result waits to be taken.
// Synchronous active-low reset clears all valid bits; no clearing pass.
// Depends on ctrgb_pkg, ctrgb_log_cell, ctrgb_exp_cell and ctrgb_div_cell.
`default_nettype none
module color_temperature_to_rgb_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [15:0]                       in_temperature_kelvin,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [ctrgb_pkg::CHANNEL_BITS-1:0]     out_red_level,
  output logic [ctrgb_pkg::CHANNEL_BITS-1:0]     out_green_level,
  output logic [ctrgb_pkg::CHANNEL_BITS-1:0]     out_blue_level
);
  import ctrgb_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS;

  logic              en;
  logic [NSTAGE-1:0] vld_r;
  logic [15:0]       k_r;

  logic [15:0] na;
  logic [15:0] nb;
  flags_t      flg0;
  flags_t      flg_r [FLG_DEPTH];

  log_t la [LOG_STEPS+1];
  log_t lb [LOG_STEPS+1];

  logic [33:0] p1_da_r, p1_db_r;
  logic [44:0] p2_lna_hi_r, p2_lna_lo_r, p2_lnb_hi_r, p2_lnb_lo_r;
  logic [44:0] p2_er_hi_r, p2_er_lo_r, p2_eg_hi_r, p2_eg_lo_r;
  logic [33:0] p3_lna_r, p3_lnb_r;
  logic [31:0] p3_er_r, p3_eg_r;
  logic [40:0] p4_va_hi_r, p4_va_lo_r, p4_vb_hi_r, p4_vb_lo_r;
  logic [59:0] p4_yr_r, p4_yg_r;
  logic [1:0]  p4_ipr_r, p4_ipg_r, p5_ipr_r, p5_ipg_r;
  logic [27:0] p5_va_r, p5_vb_r;
  logic [29:0] p5_yr_r, p5_yg_r;
  logic [29:0] y6r_r, y6g_r;
  ctx_t        ctx_r [CTX_DEPTH];
  ctx_t        ctx6;

  exp_t er [EXP_TERMS+1];
  exp_t eg [EXP_TERMS+1];
  div_t dr [DIV_STEPS+1];
  div_t dg [DIV_STEPS+1];

  logic [27:0] tv    [4];
  logic [28:0] t1_x_r[4];
  logic [28:0] t2_x_r[4];
  logic [21:0] t2_q_r[4];
  ctx_t        t1_ctx_r, t2_ctx_r;
  logic [CB-1:0] lvl [4];

  logic [CB-1:0] red_r, green_r, blue_r;

  function automatic log_t log_init(input logic [15:0] n);
    log_t        r;
    logic [3:0]  e;
    e = 4'd0;
    for (int j = 1; j < 16; j++) begin
      if (n[j]) e = 4'(j);
    end
    r.m    = 31'(n) << (5'd30 - 5'(e));
    r.e    = e;
    r.frac = 30'd0;
    return r;
  endfunction

  function automatic logic [33:0] sub_log100(input log_t l);
    logic [33:0] v;
    v = {l.e, l.frac};
    return (v > LOG2_100) ? v - LOG2_100 : 34'd0;
  endfunction

  assign en       = !vld_r[NSTAGE-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  // Front: the low range logs the temperature itself, the high range k - 6000; blue logs k - 1000.
  always_comb begin
    na = (k_r <= 16'd6600) ? k_r : k_r - 16'd6000;
    nb = k_r - 16'd1000;
    flg0.lo     = (k_r <= 16'd6600);
    flg0.bfull  = (k_r >= 16'd6600);
    flg0.bzero  = (k_r <= 16'd1900);
    flg0.smalla = (na < 16'd100);
    flg0.smallb = (nb < 16'd100);
  end

  assign la[0] = log_init(na);
  assign lb[0] = log_init(nb);

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
    ctrgb_log_cell u_la (.clk(clk), .en(en), .d_i(la[i]), .d_o(la[i+1]));
    ctrgb_log_cell u_lb (.clk(clk), .en(en), .d_i(lb[i]), .d_o(lb[i+1]));
  end

  always_comb begin
    ctx6.lo    = flg_r[FLG_DEPTH-1].lo;
    ctx6.bfull = flg_r[FLG_DEPTH-1].bfull;
    ctx6.bzero = flg_r[FLG_DEPTH-1].bzero;
    ctx6.ga    = (flg_r[FLG_DEPTH-1].smalla || p5_va_r <= GREEN_LOG_B) ? 28'd0
                 : p5_va_r - GREEN_LOG_B;
    ctx6.bb    = (flg_r[FLG_DEPTH-1].smallb || p5_vb_r <= BLUE_LOG_B) ? 28'd0
                 : p5_vb_r - BLUE_LOG_B;
    ctx6.ipr   = p5_ipr_r;
    ctx6.ipg   = p5_ipg_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r      <= in_temperature_kelvin;
      flg_r[0] <= flg0;
      for (int i = 1; i < FLG_DEPTH; i++) flg_r[i] <= flg_r[i-1];

      p1_da_r <= sub_log100(la[LOG_STEPS]);
      p1_db_r <= sub_log100(lb[LOG_STEPS]);

      p2_lna_hi_r <= 45'(p1_da_r[33:17]) * 45'(LN2_Q28);
      p2_lna_lo_r <= 45'(p1_da_r[16:0])  * 45'(LN2_Q28);
      p2_lnb_hi_r <= 45'(p1_db_r[33:17]) * 45'(LN2_Q28);
      p2_lnb_lo_r <= 45'(p1_db_r[16:0])  * 45'(LN2_Q28);
      p2_er_hi_r  <= 45'(p1_da_r[33:17]) * 45'(RED_POW_P);
      p2_er_lo_r  <= 45'(p1_da_r[16:0])  * 45'(RED_POW_P);
      p2_eg_hi_r  <= 45'(p1_da_r[33:17]) * 45'(GREEN_POW_P);
      p2_eg_lo_r  <= 45'(p1_da_r[16:0])  * 45'(GREEN_POW_P);

      p3_lna_r <= 34'(((62'(p2_lna_hi_r) << 17) + 62'(p2_lna_lo_r)) >> 28);
      p3_lnb_r <= 34'(((62'(p2_lnb_hi_r) << 17) + 62'(p2_lnb_lo_r)) >> 28);
      p3_er_r  <= 32'(((62'(p2_er_hi_r) << 17) + 62'(p2_er_lo_r)) >> 30);
      p3_eg_r  <= 32'(((62'(p2_eg_hi_r) << 17) + 62'(p2_eg_lo_r)) >> 30);

      p4_va_hi_r <= 41'(p3_lna_r[33:17]) * 41'(GREEN_LOG_A);
      p4_va_lo_r <= 41'(p3_lna_r[16:0])  * 41'(GREEN_LOG_A);
      p4_vb_hi_r <= 41'(p3_lnb_r[33:17]) * 41'(BLUE_LOG_A);
      p4_vb_lo_r <= 41'(p3_lnb_r[16:0])  * 41'(BLUE_LOG_A);
      p4_yr_r    <= 60'(p3_er_r[29:0]) * 60'(LN2_Q30);
      p4_yg_r    <= 60'(p3_eg_r[29:0]) * 60'(LN2_Q30);
      p4_ipr_r   <= p3_er_r[31:30];
      p4_ipg_r   <= p3_eg_r[31:30];

      p5_va_r  <= 28'(((58'(p4_va_hi_r) << 17) + 58'(p4_va_lo_r)) >> 30);
      p5_vb_r  <= 28'(((58'(p4_vb_hi_r) << 17) + 58'(p4_vb_lo_r)) >> 30);
      p5_yr_r  <= p4_yr_r[59:30];
      p5_yg_r  <= p4_yg_r[59:30];
      p5_ipr_r <= p4_ipr_r;
      p5_ipg_r <= p4_ipg_r;

      ctx_r[0] <= ctx6;
      y6r_r    <= p5_yr_r;
      y6g_r    <= p5_yg_r;
      for (int i = 1; i < CTX_DEPTH; i++) ctx_r[i] <= ctx_r[i-1];
    end
  end

  assign er[0] = '{term: Q30_ONE, sum: Q30_ONE, y: y6r_r, k: 5'd1};
  assign eg[0] = '{term: Q30_ONE, sum: Q30_ONE, y: y6g_r, k: 5'd1};

  for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
    ctrgb_exp_cell u_er (.clk(clk), .en(en), .d_i(er[i]), .d_o(er[i+1]));
    ctrgb_exp_cell u_eg (.clk(clk), .en(en), .d_i(eg[i]), .d_o(eg[i+1]));
  end

  // The quotient of C shifted by 30 over the exp sum fits 25 bits, so the
  // division starts with the remainder already holding C shifted by 5.
  assign dr[0] = '{rem: 31'(RED_POW_C) << 5,   dvs: er[EXP_TERMS].sum, quo: 25'd0};
  assign dg[0] = '{rem: 31'(GREEN_POW_C) << 5, dvs: eg[EXP_TERMS].sum, quo: 25'd0};

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    ctrgb_div_cell u_dr (.clk(clk), .en(en), .d_i(dr[i]), .d_o(dr[i+1]));
    ctrgb_div_cell u_dg (.clk(clk), .en(en), .d_i(dg[i]), .d_o(dg[i+1]));
  end

  always_comb begin
    tv[0] = 28'(dr[DIV_STEPS].quo >> ctx_r[CTX_DEPTH-1].ipr);
    tv[1] = 28'(dg[DIV_STEPS].quo >> ctx_r[CTX_DEPTH-1].ipg);
    tv[2] = ctx_r[CTX_DEPTH-1].ga;
    tv[3] = ctx_r[CTX_DEPTH-1].bb;
  end

  // Rounding to the channel scale; the reciprocal quotient may be one short.
  always_comb begin
    logic [28:0] rem;
    logic [21:0] q;
    for (int c = 0; c < 4; c++) begin
      rem = t2_x_r[c] - 29'(t2_q_r[c] * 22'd255);
      q   = (rem >= 29'd255) ? t2_q_r[c] + 22'd1 : t2_q_r[c];
      lvl[c] = (q > 22'(FULL_SCALE)) ? FULL_SCALE : q[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    logic [53:0] pm;
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        t1_x_r[c] <= 29'((45'(tv[c]) * 45'(FULL_SCALE) + 45'(255 * 2**15)) >> 16);
        pm         = 54'(t1_x_r[c]) * 54'(RECIP_255);
        t2_q_r[c] <= pm[53:32];
        t2_x_r[c] <= t1_x_r[c];
      end
      t1_ctx_r <= ctx_r[CTX_DEPTH-1];
      t2_ctx_r <= t1_ctx_r;

      red_r   <= t2_ctx_r.lo ? FULL_SCALE : lvl[0];
      green_r <= t2_ctx_r.lo ? lvl[2] : lvl[1];
      blue_r  <= t2_ctx_r.bfull ? FULL_SCALE : (t2_ctx_r.bzero ? '0 : lvl[3]);
    end
  end

  assign out_valid       = vld_r[NSTAGE-1];
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

endmodule
`default_nettype wire

FILE: tb/color_temperature_to_rgb_unit_test.sv
// Self-checking testbench for the colour temperature to RGB unit.
// Predicts each result with an integer fixed-point model of the blackbody fit.
// Depends on ctrgb_pkg and color_temperature_to_rgb_unit.
`default_nettype none
module color_temperature_to_rgb_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ctrgb_pkg::*;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_t;

  localparam int unsigned LATENCY = 113;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_temperature_kelvin = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHANNEL_BITS-1:0] out_red_level, out_green_level, out_blue_level;

  rgb_t pending_colours[$];
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;
  bit quiet_mode = 1'b0;

  color_temperature_to_rgb_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_temperature_kelvin(in_temperature_kelvin),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red_level(out_red_level), .out_green_level(out_green_level),
    .out_blue_level(out_blue_level)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Fixed-point helpers, all on 64-bit unsigned words.
  function automatic longint unsigned log2_fix(longint unsigned n);
    longint unsigned m, res;
    int e;
    if (n == 0) return 0;
    n &= 64'hFFFF;
    e = 0;
    while (e < 15 && (n >> (e + 1)) != 0) e++;
    m = n << (30 - e);
    res = longint'(e) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        res |= 64'd1 << i;
      end
    end
    return res;
  endfunction

  function automatic longint unsigned log2_centi(longint unsigned n);
    longint unsigned a, b;
    a = log2_fix(n);
    b = log2_fix(100);
    return a > b ? a - b : 0;
  endfunction

  function automatic longint unsigned ln_fit(longint unsigned n, longint unsigned a,
                                             longint unsigned b);
    longint unsigned ln, v;
    if (n < 100) return 0;
    ln = (log2_centi(n) * 64'd186065279) >> 28;
    v = (a * ln) >> 30;
    return v > b ? v - b : 0;
  endfunction

  function automatic longint unsigned power_fit(longint unsigned n, longint unsigned c,
                                                longint unsigned p);
    longint unsigned e, ip, f, y, term, sum;
    e = (p * log2_centi(n)) >> 30;
    ip = e >> 30;
    f = e & ((64'd1 << 30) - 1);
    y = (f * 64'd744261118) >> 30;
    term = 64'd1 << 30;
    sum = term;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * y) >> 30) / k;
      sum += term;
    end
    if (ip >= 40) return 0;
    return ((c << 30) / sum) >> ip;
  endfunction

  function automatic longint unsigned scale_level(longint unsigned v);
    longint unsigned full, r;
    full = longint'(FULL_SCALE);
    r = (v * full + (64'd255 << 15)) / (64'd255 << 16);
    return r > full ? full : r;
  endfunction

  function automatic rgb_t colour_of(logic [15:0] kelvin);
    rgb_t c;
    longint unsigned k;
    k = kelvin;
    if (k <= 6600) begin
      c.red = FULL_SCALE;
      c.green = scale_level(ln_fit(k, 6518919, 10559132));
    end else begin
      c.red = scale_level(power_fit(k - 6000, 21607136, 143027521));
      c.green = scale_level(power_fit(k - 6000, 18882375, 81083452));
    end
    if (k >= 6600) c.blue = FULL_SCALE;
    else if (k <= 1900) c.blue = '0;
    else c.blue = scale_level(ln_fit(k - 1000, 9077898, 19991416));
    return c;
  endfunction

  // Valid stays high between items sent back to back; it drops only for idling.
  task automatic send_temperature(logic [15:0] kelvin);
    int gap;
    gap = 0;
    if (!quiet_mode && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_temperature_kelvin <= kelvin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_colours.push_back(colour_of(kelvin));
    @(negedge clk);
  endtask

  // Receiver stalls on random cycles, driven at the falling edge.
  always @(negedge clk) begin
    if (!rst_n || quiet_mode) out_ready <= 1'b1;
    else if ($urandom_range(0, 5) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    rgb_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %0d %0d %0d",
                                       out_red_level, out_green_level, out_blue_level);
      end else begin
        want = pending_colours.pop_front();
        if (want.red !== out_red_level || want.green !== out_green_level ||
            want.blue !== out_blue_level) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     want.red, want.green, want.blue,
                     out_red_level, out_green_level, out_blue_level);
        end
      end
    end
  end

  task automatic test_directed();
    logic [15:0] points [20] = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd1000, 16'd1900,
      16'd1901, 16'd2000, 16'd4000, 16'd6599, 16'd6600, 16'd6601, 16'd6700,
      16'd10000, 16'd20000, 16'd40000, 16'd65534, 16'd65535, 16'hAAAA, 16'h5555};
    foreach (points[i]) send_temperature(points[i]);
  endtask

  task automatic test_drain_pause();
    // Sender holds off until every outstanding item has come back.
    in_valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: send_temperature(16'($urandom_range(1000, 12000)));
        1: send_temperature(16'($urandom_range(6500, 6700)));
        2: send_temperature(16'($urandom_range(0, 2000)));
        default: send_temperature(16'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_drain_pause();
    test_random(300);
    quiet_mode = 1'b1;
    test_random(100);
    in_valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_colours.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/ctrgb_pkg.sv
rtl/ctrgb_log_cell.sv
rtl/ctrgb_exp_cell.sv
rtl/ctrgb_div_cell.sv
rtl/color_temperature_to_rgb_unit.sv
tb/color_temperature_to_rgb_unit_test.sv
